/* rtl/pplm_pkg.sv */
// Shared constants, register indexes and format helpers for the PCM peak level meter.
package pplm_pkg;

    localparam logic [1:0] CFG_WIDTH_CODE  = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_KIND = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd2;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;
    localparam logic [1:0] KIND_FLOAT    = 2'd2;

    localparam logic [31:0] FS_U8  = 32'd255;
    localparam logic [31:0] FS_S8  = 32'd127;
    localparam logic [31:0] FS_U16 = 32'd65535;
    localparam logic [31:0] FS_S16 = 32'd32767;
    localparam logic [31:0] FS_U32 = 32'hffff_ffff;
    localparam logic [31:0] FS_S32 = 32'h7fff_ffff;

    localparam int          DIV_STEPS = 17;
    localparam logic [4:0]  DIV_LAST  = 5'(DIV_STEPS - 1);

    localparam logic [32:0] MAG_SAT   = 33'h1_0000_0000;
    localparam logic [32:0] POS_LIMIT = 33'h0_7fff_ffff;
    localparam logic [32:0] NEG_LIMIT = 33'h1_8000_0000;

    // zero marks an invalid format
    function automatic logic [31:0] full_scale(input logic [1:0] width_code,
                                               input logic [1:0] kind);
        logic [31:0] fs;
        fs = '0;
        unique case (width_code)
            WIDTH_8: begin
                if (kind == KIND_UNSIGNED) fs = FS_U8;
                else if (kind == KIND_SIGNED) fs = FS_S8;
            end
            WIDTH_16: begin
                if (kind == KIND_UNSIGNED) fs = FS_U16;
                else if (kind == KIND_SIGNED) fs = FS_S16;
            end
            WIDTH_32: begin
                if (kind == KIND_UNSIGNED) fs = FS_U32;
                else if (kind == KIND_SIGNED || kind == KIND_FLOAT) fs = FS_S32;
            end
            default: fs = '0;
        endcase
        return fs;
    endfunction

endpackage

/* rtl/pcm_peak_level_meter.sv */
// PCM peak level meter: sample decoder, running peak and iterative level divider.
//
//  channel   dir  handshake                   word
//  in        in   i_in_valid / o_in_ready     i_sample_word, i_end_of_buffer
//  out       out  o_out_valid / i_out_ready   o_decoded_sample, o_level_valid,
//                                             o_peak_clamped, o_level_fraction
//  cfg       in   i_cfg_we                    i_cfg_addr, i_cfg_wdata
//
// A word passes the decode, peak and done states before input is ready again;
// float samples add a float state. An end-of-buffer word also runs the restoring
// divider, one quotient bit per cycle. Reset is synchronous; it clears the peak
// and the output valid flag and restores the default configuration. A stalled
// output holds the result word while the next input word is accepted and decoded.
module pcm_peak_level_meter
    import pplm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [1:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_sample_word,
    input  logic               i_end_of_buffer,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [32:0] o_decoded_sample,
    output logic               o_level_valid,
    output logic [31:0]        o_peak_clamped,
    output logic [16:0]        o_level_fraction
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_FLT,
        S_PEAK,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [1:0]         r_width;
    logic [1:0]         r_kind;
    logic               r_be;
    logic [31:0]        r_peak;
    logic [31:0]        r_word;
    logic               r_eob;
    logic [31:0]        r_fs;
    logic [32:0]        r_val;
    logic [54:0]        r_prod;
    logic signed [8:0]  r_shift;
    logic               r_fneg;
    logic               r_fnan;
    logic               r_finf;
    logic [31:0]        r_pk;
    logic [32:0]        r_rem;
    logic [16:0]        r_quo;
    logic [4:0]         r_cnt;
    logic               r_o_valid;
    logic [32:0]        r_o_val;
    logic               r_o_lvl_valid;
    logic [31:0]        r_o_pk;
    logic [16:0]        r_o_lvl;

    // decode
    logic [31:0] fs_now;
    logic [15:0] raw16;
    logic [31:0] raw32;
    logic [32:0] int_val;
    logic [7:0]  f_expo;
    logic [23:0] f_mant;
    logic [54:0] f_prod;
    logic [7:0]  f_expo_eff;

    always_comb begin
        fs_now  = full_scale(r_width, r_kind);
        raw16   = r_be ? {r_word[7:0], r_word[15:8]} : r_word[15:0];
        raw32   = r_be ? {r_word[7:0], r_word[15:8], r_word[23:16], r_word[31:24]} : r_word;
        int_val = '0;
        unique case (r_width)
            WIDTH_8:  int_val = (r_kind == KIND_SIGNED) ? {{25{r_word[7]}}, r_word[7:0]}
                                                        : {25'd0, r_word[7:0]};
            WIDTH_16: int_val = (r_kind == KIND_SIGNED) ? {{17{raw16[15]}}, raw16}
                                                        : {17'd0, raw16};
            WIDTH_32: int_val = (r_kind == KIND_SIGNED) ? {raw32[31], raw32}
                                                        : {1'b0, raw32};
            default:  int_val = '0;
        endcase
        f_expo     = raw32[30:23];
        f_mant     = (f_expo == 8'd0) ? {1'b0, raw32[22:0]} : {1'b1, raw32[22:0]};
        f_expo_eff = (f_expo == 8'd0) ? 8'd1 : f_expo;
        // mant * (2^31 - 1)
        f_prod     = {f_mant, 31'd0} - {31'd0, f_mant};
    end

    // float scale, truncate and saturate
    logic [63:0] sh_val;
    logic [7:0]  rsh;
    logic [32:0] f_mag;
    logic [32:0] f_val;

    always_comb begin
        sh_val = '0;
        rsh    = 8'(-r_shift);
        f_mag  = '0;
        if (r_finf || (r_prod != '0 && r_shift > 9'sd8)) begin
            f_mag = MAG_SAT;
        end else if (r_prod == '0) begin
            f_mag = '0;
        end else if (r_shift >= 9'sd0) begin
            sh_val = {9'd0, r_prod} << r_shift[3:0];
            f_mag  = (sh_val[63:32] != '0) ? MAG_SAT : {1'b0, sh_val[31:0]};
        end else if (rsh >= 8'd64) begin
            f_mag = '0;
        end else begin
            sh_val = {9'd0, r_prod} >> rsh[5:0];
            f_mag  = (sh_val[63:32] != '0) ? MAG_SAT : {1'b0, sh_val[31:0]};
        end
        if (r_fnan) begin
            f_val = '0;
        end else if (r_fneg) begin
            f_val = (f_mag >= 33'h0_8000_0000) ? NEG_LIMIT : 33'd0 - f_mag;
        end else begin
            f_val = (f_mag > POS_LIMIT) ? POS_LIMIT : f_mag;
        end
    end

    // peak and divider step
    logic [32:0] abs_val;
    logic [31:0] peak_new;
    logic [31:0] pk_clamp;
    logic [32:0] div_cand;
    logic        div_ge;

    always_comb begin
        abs_val  = r_val[32] ? 33'd0 - r_val : r_val;
        peak_new = (abs_val[31:0] > r_peak) ? abs_val[31:0] : r_peak;
        pk_clamp = (peak_new < r_fs) ? peak_new : r_fs;
        div_cand = (r_cnt == '0) ? r_rem : {r_rem[31:0], 1'b0};
        div_ge   = div_cand >= {1'b0, r_fs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_width       <= WIDTH_16;
            r_kind        <= KIND_SIGNED;
            r_be          <= 1'b0;
            r_peak        <= '0;
            r_o_valid     <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_WIDTH_CODE:  r_width <= i_cfg_wdata;
                    CFG_SAMPLE_KIND: r_kind  <= i_cfg_wdata;
                    CFG_BIG_ENDIAN:  r_be    <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_o_valid || i_out_ready)) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_word  <= i_sample_word;
                        r_eob   <= i_end_of_buffer;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_fs    <= fs_now;
                    r_prod  <= f_prod;
                    r_shift <= $signed({1'b0, f_expo_eff}) - 9'sd150;
                    r_fneg  <= raw32[31];
                    r_fnan  <= (f_expo == 8'hff) && (raw32[22:0] != '0);
                    r_finf  <= (f_expo == 8'hff) && (raw32[22:0] == '0);
                    r_val   <= (fs_now == '0) ? 33'd0 : int_val;
                    r_state <= (fs_now != '0 && r_kind == KIND_FLOAT) ? S_FLT : S_PEAK;
                end
                S_FLT: begin
                    r_val   <= f_val;
                    r_state <= S_PEAK;
                end
                S_PEAK: begin
                    if (r_eob) begin
                        r_peak  <= '0;
                        r_pk    <= pk_clamp;
                        r_rem   <= {1'b0, pk_clamp};
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_peak  <= peak_new;
                        r_pk    <= '0;
                        r_quo   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_cand - {1'b0, r_fs} : div_cand;
                    r_quo <= {r_quo[15:0], div_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_val       <= r_val;
                        r_o_lvl_valid <= r_eob;
                        r_o_pk        <= r_pk;
                        r_o_lvl       <= (r_eob && r_fs != '0) ? r_quo : 17'd0;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_decoded_sample = $signed(r_o_val);
    assign o_level_valid    = r_o_lvl_valid;
    assign o_peak_clamped   = r_o_pk;
    assign o_level_fraction = r_o_lvl;

    a_no_level_off_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_level_valid |-> o_peak_clamped == '0 && o_level_fraction == '0)
        else $error("level fields set on a word that does not end a buffer");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_level_valid |-> o_level_fraction <= 17'h1_0000)
        else $error("level beyond full scale");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt != '0 && r_fs != '0 |-> r_rem < {1'b0, r_fs})
        else $error("divider remainder not below full scale");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready again straight after accepting a word");

endmodule
